[rtl/sjb_pkg.sv]
// sjb_pkg: shared types and codes for the sequenced jitter buffer
// no dependencies; used by sjb_cmp and sequenced_jitter_buffer_top
package sjb_pkg;

  // request type codes
  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  // result kind codes
  localparam logic [2:0] K_ACCEPT  = 3'd0;
  localparam logic [2:0] K_LATE    = 3'd1;
  localparam logic [2:0] K_DUP     = 3'd2;
  localparam logic [2:0] K_TRIM    = 3'd3;
  localparam logic [2:0] K_PLAY    = 3'd4;
  localparam logic [2:0] K_CONCEAL = 3'd5;
  localparam logic [2:0] K_WAIT    = 3'd6;
  localparam logic [2:0] K_STOP    = 3'd7;

  // reset value of the prebuffer register
  localparam logic [3:0] PREBUF_RESET = 4'd2;

  // one queue entry as held in the ram
  typedef struct packed {
    logic [15:0] seq;
    logic [15:0] hnd;
  } entry_t;

  // result of the shared sequence comparator
  typedef struct packed {
    logic newer;
    logic same;
  } cmp_res_t;

endpackage

[rtl/sjb_ram.sv]
// sjb_ram: generic single-write, single-read ram with registered read data
// no dependencies
module sjb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/sjb_cmp.sv]
// sjb_cmp: shared serial-number comparator for 16-bit sequence numbers
// depends on sjb_pkg
module sjb_cmp (
  input  logic [15:0]       a,
  input  logic [15:0]       b,
  output sjb_pkg::cmp_res_t res
);

  logic [15:0] diff;

  // a is newer than b when the wrapped distance is in the lower half range
  always_comb begin
    diff      = a - b;
    res.same  = (diff == 16'd0);
    res.newer = (diff != 16'd0) && !diff[15];
  end

endmodule

[rtl/sequenced_jitter_buffer_top.sv]
// sequenced_jitter_buffer_top: jitter buffer sequencer, queue ring and output register
// depends on sjb_pkg, sjb_ram, sjb_cmp
// arrival: late check, else queue search (read, compare per entry), shift of later entries
//   (read, write each), insert, a read and emit per trimmed frame, a reload of the expected
//   sequence; tick: wait check, head read, then play, conceal or stop; req_stall is high while
// busy; a result waiting in the output register holds the sequencer; sync reset clears count,
// head, play state, expected sequence and prebuffer (to 2), not the queue ram
module sequenced_jitter_buffer_top #(
  parameter int MAX_DEPTH = 10
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        req_type,
  input  logic [15:0] sequence_req,
  input  logic [15:0] payload_handle,
  // result channel
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  kind,
  output logic [15:0] handle,
  output logic [15:0] frame_sequence,
  output logic        last,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);

  localparam int SLOTS = MAX_DEPTH + 1;
  localparam int AW    = $clog2(SLOTS);
  localparam int CW    = $clog2(SLOTS + 1);

  // sequencer states
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_ARR_LATE  = 4'd1;
  localparam logic [3:0] S_SRCH_RD   = 4'd2;
  localparam logic [3:0] S_SRCH_CMP  = 4'd3;
  localparam logic [3:0] S_SHF_RD    = 4'd4;
  localparam logic [3:0] S_SHF_WR    = 4'd5;
  localparam logic [3:0] S_INS       = 4'd6;
  localparam logic [3:0] S_TRIM_RD   = 4'd7;
  localparam logic [3:0] S_TRIM_EMIT = 4'd8;
  localparam logic [3:0] S_EXP_RD    = 4'd9;
  localparam logic [3:0] S_EXP_SET   = 4'd10;
  localparam logic [3:0] S_TICK      = 4'd11;
  localparam logic [3:0] S_TICK_RD   = 4'd12;
  localparam logic [3:0] S_TICK_CMP  = 4'd13;

  logic [3:0]    state;
  logic [15:0]   rseq;
  logic [15:0]   rhnd;
  logic [CW-1:0] at;
  logic [CW-1:0] idx;
  logic [CW-1:0] count;
  logic [AW-1:0] head;
  logic          playing;
  logic          start;
  logic [15:0]   expected;
  logic [3:0]    prebuf;

  logic [CW-1:0] keep;
  logic [CW-1:0] count_dec;
  logic [AW-1:0] head_next;
  logic [CW-1:0] rd_off;
  logic [CW-1:0] wr_off;
  logic [CW:0]   rd_sum;
  logic [CW:0]   wr_sum;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          re;
  logic          we;
  sjb_pkg::entry_t wdata;
  sjb_pkg::entry_t rdata;
  logic [15:0]   cmp_a;
  logic [15:0]   cmp_b;
  sjb_pkg::cmp_res_t cmp;
  logic [15:0]   exp_eff;

  logic          emit;
  logic          can_load;
  logic [2:0]    e_kind;
  logic [15:0]   e_handle;
  logic [15:0]   e_seq;
  logic          e_last;

  assign req_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign can_load  = !res_valid || !res_stall;
  assign count_dec = count - CW'(1);
  assign exp_eff   = start ? rdata.seq : expected;

  // effective prebuffer depth, clamped to 1..MAX_DEPTH
  always_comb begin
    if (prebuf == 4'd0) begin
      keep = CW'(1);
    end else if (32'(prebuf) > MAX_DEPTH) begin
      keep = CW'(MAX_DEPTH);
    end else begin
      keep = CW'(prebuf);
    end
  end

  // ring addressing: queue offset plus head, wrapped once
  always_comb begin
    rd_sum = (CW+1)'(head) + (CW+1)'(rd_off);
    wr_sum = (CW+1)'(head) + (CW+1)'(wr_off);
    if (rd_sum >= (CW+1)'(SLOTS)) begin
      rd_sum = rd_sum - (CW+1)'(SLOTS);
    end
    if (wr_sum >= (CW+1)'(SLOTS)) begin
      wr_sum = wr_sum - (CW+1)'(SLOTS);
    end
    rd_addr = rd_sum[AW-1:0];
    wr_addr = wr_sum[AW-1:0];
    if (32'(head) == SLOTS - 1) begin
      head_next = '0;
    end else begin
      head_next = head + AW'(1);
    end
  end

  // per-state datapath control: ram ports, comparator operands, result fields
  always_comb begin
    re       = 1'b0;
    we       = 1'b0;
    rd_off   = '0;
    wr_off   = '0;
    wdata    = rdata;
    cmp_a    = rseq;
    cmp_b    = rseq;
    emit     = 1'b0;
    e_kind   = sjb_pkg::K_ACCEPT;
    e_handle = 16'd0;
    e_seq    = 16'd0;
    e_last   = 1'b1;
    unique case (state)
      S_ARR_LATE: begin
        cmp_a = rseq;
        cmp_b = expected - 16'd1;
        if (playing && !cmp.newer) begin
          emit     = 1'b1;
          e_kind   = sjb_pkg::K_LATE;
          e_handle = rhnd;
          e_seq    = rseq;
        end
      end
      S_SRCH_RD: begin
        re     = (at != count);
        rd_off = at;
      end
      S_SRCH_CMP: begin
        cmp_a = rdata.seq;
        cmp_b = rseq;
        if (cmp.same) begin
          emit     = 1'b1;
          e_kind   = sjb_pkg::K_DUP;
          e_handle = rhnd;
          e_seq    = rseq;
        end
      end
      S_SHF_RD: begin
        re     = (idx != at);
        rd_off = idx - CW'(1);
      end
      S_SHF_WR: begin
        we     = 1'b1;
        wr_off = idx;
        wdata  = rdata;
      end
      S_INS: begin
        we        = can_load;
        wr_off    = at;
        wdata.seq = rseq;
        wdata.hnd = rhnd;
        emit      = 1'b1;
        e_kind    = sjb_pkg::K_ACCEPT;
        e_handle  = rhnd;
        e_seq     = rseq;
        e_last    = (count != CW'(MAX_DEPTH));
      end
      S_TRIM_RD: begin
        re = 1'b1;
      end
      S_TRIM_EMIT: begin
        emit     = 1'b1;
        e_kind   = sjb_pkg::K_TRIM;
        e_handle = rdata.hnd;
        e_seq    = rdata.seq;
        e_last   = (count_dec == keep);
      end
      S_EXP_RD: begin
        re = 1'b1;
      end
      S_EXP_SET: begin
        re = 1'b0;
      end
      S_TICK: begin
        if (!playing && (count < keep)) begin
          emit   = 1'b1;
          e_kind = sjb_pkg::K_WAIT;
        end
      end
      S_TICK_RD: begin
        if (count == '0) begin
          emit   = 1'b1;
          e_kind = sjb_pkg::K_STOP;
          e_seq  = expected;
        end else begin
          re = 1'b1;
        end
      end
      S_TICK_CMP: begin
        cmp_a = rdata.seq;
        cmp_b = exp_eff;
        emit  = 1'b1;
        e_seq = exp_eff;
        if (cmp.same) begin
          e_kind   = sjb_pkg::K_PLAY;
          e_handle = rdata.hnd;
        end else begin
          e_kind = sjb_pkg::K_CONCEAL;
        end
      end
      default: begin
        re = 1'b0;
      end
    endcase
  end

  // queue storage
  sjb_ram #(
    .WIDTH($bits(sjb_pkg::entry_t)),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(wr_addr),
    .wdata(wdata),
    .re   (re),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  // shared sequence comparator
  sjb_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .res(cmp)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit && can_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && can_load) begin
      kind           <= e_kind;
      handle         <= e_handle;
      frame_sequence <= e_seq;
      last           <= e_last;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      prebuf <= sjb_pkg::PREBUF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      prebuf <= cfg_data;
    end
  end

  // request payload capture
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      rseq <= sequence_req;
      rhnd <= payload_handle;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      head     <= '0;
      playing  <= 1'b0;
      start    <= 1'b0;
      expected <= 16'd0;
      at       <= '0;
      idx      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= (req_type == sjb_pkg::REQ_TICK) ? S_TICK : S_ARR_LATE;
          end
        end
        S_ARR_LATE: begin
          if (emit) begin
            if (can_load) begin
              state <= S_IDLE;
            end
          end else begin
            at    <= '0;
            state <= S_SRCH_RD;
          end
        end
        S_SRCH_RD: begin
          if (at == count) begin
            idx   <= count;
            state <= S_SHF_RD;
          end else begin
            state <= S_SRCH_CMP;
          end
        end
        S_SRCH_CMP: begin
          if (cmp.same) begin
            if (can_load) begin
              state <= S_IDLE;
            end
          end else if (cmp.newer) begin
            idx   <= count;
            state <= S_SHF_RD;
          end else begin
            at    <= at + CW'(1);
            state <= S_SRCH_RD;
          end
        end
        S_SHF_RD: begin
          state <= (idx == at) ? S_INS : S_SHF_WR;
        end
        S_SHF_WR: begin
          idx   <= idx - CW'(1);
          state <= S_SHF_RD;
        end
        S_INS: begin
          if (can_load) begin
            count <= count + CW'(1);
            state <= (count == CW'(MAX_DEPTH)) ? S_TRIM_RD : S_IDLE;
          end
        end
        S_TRIM_RD: begin
          state <= S_TRIM_EMIT;
        end
        S_TRIM_EMIT: begin
          if (can_load) begin
            head  <= head_next;
            count <= count_dec;
            state <= (count_dec > keep) ? S_TRIM_RD : S_EXP_RD;
          end
        end
        S_EXP_RD: begin
          state <= S_EXP_SET;
        end
        S_EXP_SET: begin
          expected <= rdata.seq;
          state    <= S_IDLE;
        end
        S_TICK: begin
          if (!playing) begin
            if (count < keep) begin
              if (can_load) begin
                state <= S_IDLE;
              end
            end else begin
              playing <= 1'b1;
              start   <= 1'b1;
              state   <= S_TICK_RD;
            end
          end else begin
            start <= 1'b0;
            state <= S_TICK_RD;
          end
        end
        S_TICK_RD: begin
          if (count == '0) begin
            if (can_load) begin
              playing <= 1'b0;
              state   <= S_IDLE;
            end
          end else begin
            state <= S_TICK_CMP;
          end
        end
        S_TICK_CMP: begin
          if (can_load) begin
            expected <= exp_eff + 16'd1;
            if (cmp.same) begin
              head  <= head_next;
              count <= count_dec;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // queue never holds more than the ring size
  assert property (@(posedge clk) disable iff (rst) 32'(count) <= SLOTS)
    else $error("queue count beyond ring size");

  // ring head stays inside the ram
  assert property (@(posedge clk) disable iff (rst) 32'(head) < SLOTS)
    else $error("ring head out of range");

  // an accepted request always starts the sequencer
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state != S_IDLE))
    else $error("request accepted but sequencer stayed idle");

  // a stop result always leaves playout stopped
  assert property (@(posedge clk) disable iff (rst)
    (emit && can_load && e_kind == sjb_pkg::K_STOP) |=> !playing)
    else $error("stop reported while still playing");

  // a trim only happens from a full queue down toward the prebuffer depth
  assert property (@(posedge clk) disable iff (rst)
    (state == S_TRIM_EMIT) |-> (count > keep))
    else $error("trim with queue already at prebuffer depth");

endmodule

[sim/tb_sequenced_jitter_buffer_top.sv]
`timescale 1ns / 100ps
// tb_sequenced_jitter_buffer_top: self-checking bench for the sequenced jitter buffer
// depends on sjb_pkg and sequenced_jitter_buffer_top; a playout predictor class checks
// every result in order while random voice streams, gaps and stalls drive the block

module tb_sequenced_jitter_buffer_top;

  localparam int DEPTH_LIMIT   = 10;
  localparam int SLOT_COUNT    = DEPTH_LIMIT + 1;
  localparam int CYCLE_LIMIT   = 800000;
  localparam int SETTLE_CYCLES = 60;
  localparam int PHASE_ITEMS   = 42;

  // one expected or observed result
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] handle;
    logic [15:0] fseq;
    logic        last;
  } result_t;

  // playout predictor and the results it still expects, oldest first
  class playout_scoreboard;
    logic [15:0] slot_seq [SLOT_COUNT];
    logic [15:0] slot_hnd [SLOT_COUNT];
    int unsigned depth;
    bit          playing;
    logic [15:0] next_seq;
    logic [3:0]  prebuf;
    result_t     pending_results [$];
    int unsigned failures;
    int unsigned kind_count [8];

    function new();
      depth    = 0;
      playing  = 1'b0;
      next_seq = '0;
      prebuf   = sjb_pkg::PREBUF_RESET;
      failures = 0;
      foreach (kind_count[k]) kind_count[k] = 0;
    endfunction

    // serial-number order: a exactly half the range away is not newer
    function bit is_newer(logic [15:0] a, logic [15:0] b);
      logic [15:0] d;
      d = a - b;
      return (d != 16'd0) && (d < 16'h8000);
    endfunction

    // prebuffer value clamped to 1..DEPTH_LIMIT
    function int unsigned keep_depth();
      if (prebuf == 4'd0) return 1;
      if (prebuf > DEPTH_LIMIT) return DEPTH_LIMIT;
      return int'(prebuf);
    endfunction

    function void push(logic [2:0] k, logic [15:0] h, logic [15:0] s);
      result_t r;
      r.kind   = k;
      r.handle = h;
      r.fseq   = s;
      r.last   = 1'b0;
      pending_results = {pending_results, r};
      kind_count[k]++;
    endfunction

    function void drop_oldest();
      int unsigned i;
      for (i = 1; i < depth; i++) begin
        slot_seq[i-1] = slot_seq[i];
        slot_hnd[i-1] = slot_hnd[i];
      end
      if (depth > 0) depth--;
    endfunction

    // work out the results of one accepted request
    function void note_request(logic t, logic [15:0] s, logic [15:0] h);
      int unsigned at;
      int unsigned i;
      int unsigned keep;
      logic [15:0] prev;
      bit          done;
      if (t == sjb_pkg::REQ_ARRIVAL) begin
        prev = next_seq - 16'd1;
        at   = 0;
        done = 1'b0;
        if (playing && !is_newer(s, prev)) begin
          push(sjb_pkg::K_LATE, h, s);
          done = 1'b1;
        end
        // find the insert point, catching duplicates on the way
        while (!done && at < depth && !is_newer(slot_seq[at], s)) begin
          if (slot_seq[at] == s) begin
            push(sjb_pkg::K_DUP, h, s);
            done = 1'b1;
          end else begin
            at++;
          end
        end
        if (!done) begin
          for (i = depth; i > at; i--) begin
            slot_seq[i] = slot_seq[i-1];
            slot_hnd[i] = slot_hnd[i-1];
          end
          slot_seq[at] = s;
          slot_hnd[at] = h;
          depth++;
          push(sjb_pkg::K_ACCEPT, h, s);
          // overflow: trim down to the prebuffer depth, oldest first
          if (depth > DEPTH_LIMIT) begin
            keep = keep_depth();
            while (depth > keep) begin
              push(sjb_pkg::K_TRIM, slot_hnd[0], slot_seq[0]);
              drop_oldest();
            end
            next_seq = slot_seq[0];
          end
        end
      end else begin
        if (!playing && depth < keep_depth()) begin
          push(sjb_pkg::K_WAIT, 16'd0, 16'd0);
        end else begin
          if (!playing) begin
            playing  = 1'b1;
            next_seq = slot_seq[0];
          end
          if (depth > 0 && slot_seq[0] == next_seq) begin
            push(sjb_pkg::K_PLAY, slot_hnd[0], next_seq);
            drop_oldest();
            next_seq = next_seq + 16'd1;
          end else if (depth > 0) begin
            push(sjb_pkg::K_CONCEAL, 16'd0, next_seq);
            next_seq = next_seq + 16'd1;
          end else begin
            playing = 1'b0;
            push(sjb_pkg::K_STOP, 16'd0, next_seq);
          end
        end
      end
      // mark the final result of this request
      pending_results[pending_results.size()-1].last = 1'b1;
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d handle %h frame_sequence %h last %b",
               got.kind, got.handle, got.fseq, got.last);
        failures++;
        return;
      end
      want = pending_results[0];
      pending_results.delete(0);
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, got.kind);
        failures++;
      end
      if (got.handle !== want.handle) begin
        $error("handle: expected %h, actual %h", want.handle, got.handle);
        failures++;
      end
      if (got.fseq !== want.fseq) begin
        $error("frame_sequence: expected %h, actual %h", want.fseq, got.fseq);
        failures++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %b, actual %b", want.last, got.last);
        failures++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  logic        req_type;
  logic [15:0] sequence_req;
  logic [15:0] payload_handle;
  logic        res_valid;
  logic        res_stall;
  logic [2:0]  kind;
  logic [15:0] handle;
  logic [15:0] frame_sequence;
  logic        last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_data;

  playout_scoreboard sb;
  int unsigned       cycles;
  int unsigned       requests_sent;
  int unsigned       results_seen;
  logic [15:0]       stream_seq;

  sequenced_jitter_buffer_top #(
    .MAX_DEPTH(DEPTH_LIMIT)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req_type      (req_type),
    .sequence_req  (sequence_req),
    .payload_handle(payload_handle),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .kind          (kind),
    .handle        (handle),
    .frame_sequence(frame_sequence),
    .last          (last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles,
               sb.pending_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // gap before a request: mostly none or short, a few long
  function automatic int unsigned pick_gap(bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // offer one request and hold it until accepted
  task automatic send_request(input logic t, input logic [15:0] s, input logic [15:0] h,
                              input int unsigned gap);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid      <= 1'b1;
    req_type       <= t;
    sequence_req   <= s;
    payload_handle <= h;
    do @(posedge clk); while (req_stall !== 1'b0);
    sb.note_request(t, s, h);
    requests_sent++;
  endtask

  task automatic wait_drained();
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  // prebuffer write, only with the block idle
  task automatic write_prebuffer(input logic [3:0] v);
    req_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    sb.prebuf = v;
  endtask

  // a jittery voice stream with losses, retransmits, bursts and stray frames
  task automatic run_stream(input int unsigned n, input bit steady);
    int unsigned r;
    int unsigned burst;
    logic [15:0] jit;
    logic [15:0] s;
    logic        t;
    burst = 0;
    repeat (n) begin
      r   = $urandom_range(0, 99);
      jit = 16'($urandom_range(0, 6));
      t   = sjb_pkg::REQ_ARRIVAL;
      s   = stream_seq + jit - 16'd2;
      if (burst > 0) begin
        burst--;
        stream_seq = stream_seq + 16'd1;
      end else if (r < 42) begin
        t = sjb_pkg::REQ_TICK;
        s = 16'($urandom);
      end else if (r < 80) begin
        stream_seq = stream_seq + (($urandom_range(0, 9) == 0) ? 16'd2 : 16'd1);
      end else if (r < 88) begin
        s = stream_seq - 16'($urandom_range(1, 4));
      end else if (r < 93) begin
        burst      = $urandom_range(8, 14);
        stream_seq = stream_seq + 16'd1;
      end else begin
        s = 16'($urandom);
      end
      send_request(t, s, 16'($urandom), pick_gap(steady));
    end
  endtask

  // result side: random stalls, calm stretches and one long hold-off
  initial begin : result_sink
    int unsigned hold;
    int unsigned stretch;
    int unsigned r;
    bit          steady;
    bit          held_once;
    result_t     got;
    res_stall    = 1'b0;
    results_seen = 0;
    hold         = 0;
    stretch      = 0;
    steady       = 1'b1;
    held_once    = 1'b0;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && res_valid === 1'b1 && res_stall === 1'b0) begin
        got.kind   = kind;
        got.handle = handle;
        got.fseq   = frame_sequence;
        got.last   = last;
        sb.check_result(got);
        results_seen++;
      end
      if (stretch == 0) begin
        steady  = ($urandom_range(0, 3) == 0);
        stretch = $urandom_range(50, 300);
      end else begin
        stretch--;
      end
      // back up the block while the sender keeps offering
      if (!held_once && results_seen >= 150 && req_valid === 1'b1) begin
        held_once = 1'b1;
        hold      = 500;
      end
      if (hold > 0) begin
        res_stall <= 1'b1;
        hold--;
      end else if (steady) begin
        res_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          res_stall <= 1'b0;
        end else if (r < 95) begin
          res_stall <= 1'b1;
          hold = $urandom_range(0, 2);
        end else begin
          res_stall <= 1'b1;
          hold = $urandom_range(10, 40);
        end
      end
    end
  end

  initial begin : stimulus
    logic [3:0] settings [7];
    int         p;
    sb             = new();
    rst            = 1'b1;
    req_valid      = 1'b0;
    req_type       = sjb_pkg::REQ_ARRIVAL;
    sequence_req   = '0;
    payload_handle = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    requests_sent  = 0;
    stream_seq     = '0;
    settings       = '{4'd0, 4'd1, 4'd10, 4'd15, 4'd5, 4'd3, 4'd0};
    settings[6]    = 4'($urandom_range(0, 15));
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: wait, wrap ordering, start, late, duplicate, conceal, stop,
    // half-range distance both for late check and for queue order
    send_request(sjb_pkg::REQ_TICK,    16'h0000, 16'h0000, pick_gap(1'b0));
    send_request(sjb_pkg::REQ_ARRIVAL, 16'hFFFF, 16'h0000, pick_gap(1'b0));
    send_request(sjb_pkg::REQ_TICK,    16'hFFFF, 16'hFFFF, pick_gap(1'b0));
    send_request(sjb_pkg::REQ_ARRIVAL, 16'h0000, 16'hFFFF, pick_gap(1'b0));
    send_request(sjb_pkg::REQ_ARRIVAL, 16'h0002, 16'h1234, pick_gap(1'b0));
    send_request(sjb_pkg::REQ_TICK,    16'h0000, 16'h0000, pick_gap(1'b0));
    send_request(sjb_pkg::REQ_ARRIVAL, 16'hFFFF, 16'h4321, pick_gap(1'b0));
    send_request(sjb_pkg::REQ_ARRIVAL, 16'h0002, 16'h5555, pick_gap(1'b0));
    send_request(sjb_pkg::REQ_TICK,    16'h0000, 16'h0000, pick_gap(1'b0));
    send_request(sjb_pkg::REQ_TICK,    16'h0000, 16'h0000, pick_gap(1'b0));
    send_request(sjb_pkg::REQ_ARRIVAL, 16'h8001, 16'hAAAA, pick_gap(1'b0));
    send_request(sjb_pkg::REQ_TICK,    16'h0000, 16'h0000, pick_gap(1'b0));
    send_request(sjb_pkg::REQ_TICK,    16'h0000, 16'h0000, pick_gap(1'b0));
    send_request(sjb_pkg::REQ_ARRIVAL, 16'h8003, 16'h0F0F, pick_gap(1'b0));
    send_request(sjb_pkg::REQ_ARRIVAL, 16'h0003, 16'hF0F0, pick_gap(1'b0));
    send_request(sjb_pkg::REQ_TICK,    16'h0000, 16'h0000, pick_gap(1'b0));
    send_request(sjb_pkg::REQ_TICK,    16'h0000, 16'h0000, pick_gap(1'b0));

    // random streams, one prebuffer setting per phase
    for (p = 0; p < 7; p++) begin
      write_prebuffer(settings[p]);
      stream_seq = (p == 2) ? 16'hFFF0 : 16'($urandom);
      run_stream(PHASE_ITEMS, p == 3);
    end

    req_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("ran %0d requests giving %0d results over prebuffer 2, 0, 1, 10, 15, 5, 3, %0d",
             requests_sent, results_seen, settings[6]);
    $display("seen: %0d trimmed, %0d concealed, %0d late, %0d duplicate, %0d stopped",
             sb.kind_count[sjb_pkg::K_TRIM], sb.kind_count[sjb_pkg::K_CONCEAL],
             sb.kind_count[sjb_pkg::K_LATE], sb.kind_count[sjb_pkg::K_DUP],
             sb.kind_count[sjb_pkg::K_STOP]);
    if (sb.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
